@@ rtl/tcp_pkg.sv @@
// Shared types and constants for the transfer chunk planner.
`default_nettype none

package tcp_pkg;

  localparam int SIZE_W  = 40;
  localparam int CHUNK_W = 32;
  localparam int IDX_W   = 32;
  localparam int OFF_W   = 64;
  localparam int PROD_W  = SIZE_W + CHUNK_W;
  localparam int ADDR_W  = 4;
  localparam int PDATA_W = 64;

  localparam int DIV_STEPS = SIZE_W;
  localparam int MUL_STEPS = CHUNK_W;
  localparam int CNT_W     = 6;

  localparam logic REG_FILE_SIZE  = 1'b0;
  localparam logic REG_CHUNK_SIZE = 1'b1;

  typedef enum logic [2:0] {
    MODE_START   = 3'd0,
    MODE_ADVANCE = 3'd1,
    MODE_CANCEL  = 3'd2,
    MODE_FAIL    = 3'd3,
    MODE_RESET   = 3'd4,
    MODE_QUERY   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_READING   = 3'd1,
    ST_DONE      = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_FAILED    = 3'd4
  } status_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_DIV,
    S_CHK,
    S_MUL_B,
    S_LEN_B,
    S_SUM_B,
    S_MUL_Q,
    S_LEN_Q
  } seq_state_t;

  typedef struct packed {
    logic                start;
    alu_op_t             op;
    logic [SIZE_W-1:0]   a;
    logic [CHUNK_W-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic                done;
    logic [PROD_W-1:0]   prod;
    logic [SIZE_W-1:0]   quot;
    logic [CHUNK_W-1:0]  rem;
  } alu_rsp_t;

endpackage

`default_nettype wire

@@ rtl/tcp_if.sv @@
// Valid/ready channel interfaces for commands and results.
`default_nettype none

interface tcp_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [31:0] chunk_index;

  modport source (output valid, mode, chunk_index, input ready);
  modport sink   (input valid, mode, chunk_index, output ready);
endinterface

interface tcp_res_if;
  logic        valid;
  logic        ready;
  logic [39:0] total_chunks;
  logic [63:0] chunk_offset;
  logic [31:0] chunk_length;
  logic        chunk_is_last;
  logic        index_valid;
  logic [39:0] chunks_done;
  logic [63:0] bytes_done;
  logic [2:0]  status;

  modport source (output valid, total_chunks, chunk_offset, chunk_length, chunk_is_last,
                  index_valid, chunks_done, bytes_done, status, input ready);
  modport sink   (input valid, total_chunks, chunk_offset, chunk_length, chunk_is_last,
                  index_valid, chunks_done, bytes_done, status, output ready);
endinterface

`default_nettype wire

@@ rtl/tcp_apb.sv @@
// APB configuration registers: file size and chunk size.
`default_nettype none

module tcp_apb (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tcp_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [tcp_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tcp_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output logic      [tcp_pkg::SIZE_W-1:0]   file_size,
  output logic      [tcp_pkg::CHUNK_W-1:0]  chunk_size
);

  logic reg_sel;
  logic wr_en;

  // 8-byte register stride; only bit 3 selects
  assign reg_sel = paddr[3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size  <= '0;
      chunk_size <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        tcp_pkg::REG_FILE_SIZE:  file_size  <= pwdata[tcp_pkg::SIZE_W-1:0];
        tcp_pkg::REG_CHUNK_SIZE: chunk_size <= pwdata[tcp_pkg::CHUNK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      tcp_pkg::REG_FILE_SIZE:
        prdata = {{(tcp_pkg::PDATA_W-tcp_pkg::SIZE_W){1'b0}}, file_size};
      tcp_pkg::REG_CHUNK_SIZE:
        prdata = {{(tcp_pkg::PDATA_W-tcp_pkg::CHUNK_W){1'b0}}, chunk_size};
      default: prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/tcp_alu.sv @@
// Shared iterative unit: shift-add multiply and restoring divide on one adder.
`default_nettype none

module tcp_alu (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tcp_pkg::alu_req_t req,
  output tcp_pkg::alu_rsp_t      rsp
);

  logic                          busy;
  logic                          done;
  tcp_pkg::alu_op_t              op_r;
  logic [tcp_pkg::SIZE_W-1:0]    a_r;
  logic [tcp_pkg::CHUNK_W-1:0]   b_r;
  logic [tcp_pkg::PROD_W-1:0]    acc;
  logic [tcp_pkg::SIZE_W-1:0]    qr;
  logic [tcp_pkg::CNT_W-1:0]     count;

  logic [tcp_pkg::CHUNK_W:0]     rem_sh;
  logic [tcp_pkg::PROD_W-1:0]    opx;
  logic [tcp_pkg::PROD_W-1:0]    opy;
  logic [tcp_pkg::PROD_W-1:0]    sum;
  logic                          fits;

  assign rem_sh = {acc[tcp_pkg::CHUNK_W-1:0], qr[tcp_pkg::SIZE_W-1]};

  always_comb begin
    if (op_r == tcp_pkg::OP_MUL) begin
      opx = {acc[tcp_pkg::PROD_W-2:0], 1'b0};
      opy = qr[tcp_pkg::SIZE_W-1] ?
            {{(tcp_pkg::PROD_W-tcp_pkg::SIZE_W){1'b0}}, a_r} : '0;
      sum = opx + opy;
    end else begin
      opx = {{(tcp_pkg::PROD_W-tcp_pkg::CHUNK_W-1){1'b0}}, rem_sh};
      opy = ~{{(tcp_pkg::PROD_W-tcp_pkg::CHUNK_W){1'b0}}, b_r};
      sum = opx + opy + {{(tcp_pkg::PROD_W-1){1'b0}}, 1'b1};
    end
  end

  assign fits = ~sum[tcp_pkg::PROD_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op_r <= req.op;
      a_r  <= req.a;
      b_r  <= req.b;
      acc  <= '0;
      if (req.op == tcp_pkg::OP_DIV) begin
        qr    <= req.a;
        count <= tcp_pkg::CNT_W'(tcp_pkg::DIV_STEPS - 1);
      end else begin
        qr    <= {req.b, {(tcp_pkg::SIZE_W-tcp_pkg::CHUNK_W){1'b0}}};
        count <= tcp_pkg::CNT_W'(tcp_pkg::MUL_STEPS - 1);
      end
    end else if (busy) begin
      count <= count - 1'b1;
      if (op_r == tcp_pkg::OP_MUL) begin
        acc <= sum;
        qr  <= {qr[tcp_pkg::SIZE_W-2:0], 1'b0};
      end else begin
        acc <= fits ? sum : {{(tcp_pkg::PROD_W-tcp_pkg::CHUNK_W-1){1'b0}}, rem_sh};
        qr  <= {qr[tcp_pkg::SIZE_W-2:0], fits};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;
  assign rsp.quot = qr;
  assign rsp.rem  = acc[tcp_pkg::CHUNK_W-1:0];

endmodule

`default_nettype wire

@@ rtl/transfer_chunk_planner.sv @@
// Top level: command sequencer around the shared multiply/divide unit.
//
//   channel  dir  handshake        payload
//   cmd      in   valid/ready      mode, chunk_index
//   res      out  valid/ready      total_chunks .. status
//   apb      in   psel/penable     file_size (0x0), chunk_size (0x8)
//
// One command at a time; cmd.ready is high only while the sequencer is idle.
// Nothing sent, or done: res.valid after one 32-step multiply for the offset.
// Chunks sent and not done, in any mode: a second multiply first, for bytes_done.
// Start with both sizes non-zero adds the 40-step divide before these.
// Next accept in the cycle after the result registers; a stalled result holds the sequencer.
// Reset clears the progress state, the config and res.valid.
`default_nettype none

module transfer_chunk_planner (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tcp_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [tcp_pkg::PDATA_W-1:0]  pwdata,
  output logic      [tcp_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  tcp_cmd_if.sink                           cmd,
  tcp_res_if.source                         res
);

  localparam int SW = tcp_pkg::SIZE_W;
  localparam int CW = tcp_pkg::CHUNK_W;
  localparam int OW = tcp_pkg::OFF_W;
  localparam int PW = tcp_pkg::PROD_W;

  logic [SW-1:0]          file_size;
  logic [CW-1:0]          chunk_size;

  tcp_pkg::seq_state_t    state, state_next;
  tcp_pkg::alu_req_t      alu_req;
  tcp_pkg::alu_rsp_t      alu_rsp;

  logic [2:0]             mode_r;
  logic [tcp_pkg::IDX_W-1:0] idx_r;
  logic [SW-1:0]          latched_size;
  logic [SW-1:0]          chunk_total;
  logic [SW-1:0]          current_chunk;
  logic [SW-1:0]          sent_count;
  tcp_pkg::status_t       upload_status;
  logic [OW-1:0]          off_r;
  logic [CW-1:0]          len_r;
  logic [OW-1:0]          bytes_r;

  logic                   out_valid;
  logic [SW-1:0]          out_total;
  logic [OW-1:0]          out_offset;
  logic [CW-1:0]          out_length;
  logic                   out_last;
  logic                   out_index_valid;
  logic [SW-1:0]          out_done;
  logic [OW-1:0]          out_bytes;
  tcp_pkg::status_t       out_status;

  logic [SW-1:0]          cc_inc;
  logic [OW-1:0]          rem_full;
  logic                   is_short;
  logic [CW-1:0]          len_calc;
  logic                   valid_b;
  logic                   valid_q;
  logic [OW:0]            bytes_sum;
  logic                   emit;

  tcp_apb u_apb (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .file_size  (file_size),
    .chunk_size (chunk_size)
  );

  tcp_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // chunk length from the offset currently held in off_r
  assign rem_full  = (off_r < {{(OW-SW){1'b0}}, latched_size}) ?
                     {{(OW-SW){1'b0}}, latched_size} - off_r : '0;
  assign is_short  = rem_full < {{(OW-CW){1'b0}}, chunk_size};
  assign len_calc  = is_short ? rem_full[CW-1:0] : chunk_size;
  assign valid_b   = (sent_count - 1'b1) < chunk_total;
  assign valid_q   = {{(SW-tcp_pkg::IDX_W){1'b0}}, idx_r} < chunk_total;
  assign bytes_sum = {1'b0, off_r} + {{(OW-CW+1){1'b0}}, len_r};
  assign cc_inc    = (current_chunk == '1) ? current_chunk : current_chunk + 1'b1;
  assign emit      = (state == tcp_pkg::S_LEN_Q) && (!out_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    alu_req.start = 1'b0;
    alu_req.op    = tcp_pkg::OP_MUL;
    alu_req.a     = {{(SW-tcp_pkg::IDX_W){1'b0}}, idx_r};
    alu_req.b     = chunk_size;
    unique case (state)
      tcp_pkg::S_IDLE: begin
        if (cmd.valid) state_next = tcp_pkg::S_CMD;
      end
      tcp_pkg::S_CMD: begin
        if (mode_r == tcp_pkg::MODE_START && file_size != '0 && chunk_size != '0) begin
          alu_req.start = 1'b1;
          alu_req.op    = tcp_pkg::OP_DIV;
          alu_req.a     = file_size;
          state_next    = tcp_pkg::S_DIV;
        end else begin
          state_next = tcp_pkg::S_CHK;
        end
      end
      tcp_pkg::S_DIV: begin
        if (alu_rsp.done) state_next = tcp_pkg::S_CHK;
      end
      tcp_pkg::S_CHK: begin
        alu_req.start = 1'b1;
        if (sent_count != '0 && upload_status != tcp_pkg::ST_DONE) begin
          alu_req.a  = sent_count - 1'b1;
          state_next = tcp_pkg::S_MUL_B;
        end else begin
          state_next = tcp_pkg::S_MUL_Q;
        end
      end
      tcp_pkg::S_MUL_B: begin
        if (alu_rsp.done) state_next = tcp_pkg::S_LEN_B;
      end
      tcp_pkg::S_LEN_B: state_next = tcp_pkg::S_SUM_B;
      tcp_pkg::S_SUM_B: begin
        alu_req.start = 1'b1;
        state_next    = tcp_pkg::S_MUL_Q;
      end
      tcp_pkg::S_MUL_Q: begin
        if (alu_rsp.done) state_next = tcp_pkg::S_LEN_Q;
      end
      tcp_pkg::S_LEN_Q: begin
        if (emit) state_next = tcp_pkg::S_IDLE;
      end
      default: state_next = tcp_pkg::S_IDLE;
    endcase
  end

  assign cmd.ready = (state == tcp_pkg::S_IDLE);

  // progress state
  always_ff @(posedge clk) begin
    if (rst) begin
      latched_size  <= '0;
      chunk_total   <= '0;
      current_chunk <= '0;
      sent_count    <= '0;
      upload_status <= tcp_pkg::ST_IDLE;
    end else if (state == tcp_pkg::S_CMD) begin
      case (mode_r)
        tcp_pkg::MODE_START: begin
          latched_size <= file_size;
          if (file_size == '0 || chunk_size == '0) chunk_total <= '0;
        end
        tcp_pkg::MODE_ADVANCE: begin
          if (sent_count != '1) sent_count <= sent_count + 1'b1;
          current_chunk <= cc_inc;
          upload_status <= (cc_inc >= chunk_total) ? tcp_pkg::ST_DONE : tcp_pkg::ST_READING;
        end
        tcp_pkg::MODE_CANCEL: upload_status <= tcp_pkg::ST_CANCELLED;
        tcp_pkg::MODE_FAIL:   upload_status <= tcp_pkg::ST_FAILED;
        tcp_pkg::MODE_RESET: begin
          latched_size  <= '0;
          chunk_total   <= '0;
          current_chunk <= '0;
          sent_count    <= '0;
          upload_status <= tcp_pkg::ST_IDLE;
        end
        default: ;
      endcase
    end else if (state == tcp_pkg::S_DIV && alu_rsp.done) begin
      chunk_total   <= alu_rsp.quot + {{(SW-1){1'b0}}, (alu_rsp.rem != '0)};
      current_chunk <= '0;
      sent_count    <= '0;
      upload_status <= tcp_pkg::ST_IDLE;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == tcp_pkg::S_IDLE && cmd.valid) begin
      mode_r <= cmd.mode;
      idx_r  <= cmd.chunk_index;
    end
    if (state == tcp_pkg::S_CHK) begin
      bytes_r <= (sent_count == '0) ? '0 : {{(OW-SW){1'b0}}, latched_size};
    end
    if (state == tcp_pkg::S_MUL_B && alu_rsp.done) begin
      off_r <= (alu_rsp.prod[PW-1:OW] != '0) ? '1 : alu_rsp.prod[OW-1:0];
    end
    if (state == tcp_pkg::S_LEN_B) begin
      len_r <= valid_b ? len_calc : '0;
    end
    if (state == tcp_pkg::S_SUM_B) begin
      bytes_r <= bytes_sum[OW] ? '1 : bytes_sum[OW-1:0];
    end
    if (state == tcp_pkg::S_MUL_Q && alu_rsp.done) begin
      off_r <= alu_rsp.prod[OW-1:0];
    end
    if (emit) begin
      out_total       <= chunk_total;
      out_offset      <= off_r;
      out_length      <= valid_q ? len_calc : '0;
      out_last        <= valid_q & is_short;
      out_index_valid <= valid_q;
      out_done        <= sent_count;
      out_bytes       <= bytes_r;
      out_status      <= upload_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res.valid         = out_valid;
  assign res.total_chunks  = out_total;
  assign res.chunk_offset  = out_offset;
  assign res.chunk_length  = out_length;
  assign res.chunk_is_last = out_last;
  assign res.index_valid   = out_index_valid;
  assign res.chunks_done   = out_done;
  assign res.bytes_done    = out_bytes;
  assign res.status        = out_status;

  a_alu_start_state: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |-> (state == tcp_pkg::S_CMD || state == tcp_pkg::S_CHK ||
                       state == tcp_pkg::S_SUM_B))
    else $error("shared unit started outside a launch state");

  a_alu_done_state: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> (state == tcp_pkg::S_DIV || state == tcp_pkg::S_MUL_B ||
                      state == tcp_pkg::S_MUL_Q))
    else $error("shared unit finished while sequencer not waiting");

  a_advance_count: assert property (@(posedge clk) disable iff (rst)
    (state == tcp_pkg::S_CMD && mode_r == tcp_pkg::MODE_ADVANCE && sent_count != '1)
    |=> sent_count == $past(sent_count) + 1'b1)
    else $error("advance did not step the sent count");

  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |=> (out_valid && $stable(out_bytes)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ verif/transfer_chunk_planner_tb.sv @@
// Self-checking testbench for the transfer chunk planner: directed table then random phases.
module transfer_chunk_planner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          RANDOM_ITEMS = 800;
  localparam int          QUIET_TAIL   = 120;
  localparam logic [2:0]  MODE_SPARE_6 = 3'd6;
  localparam logic [2:0]  MODE_SPARE_7 = 3'd7;
  localparam logic [39:0] SIZE_MAX     = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] CHUNK_MAX    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [39:0]      total;
    logic [63:0]      offset;
    logic [31:0]      length;
    logic             last;
    logic             ok;
    logic [39:0]      done;
    logic [63:0]      bytes;
    tcp_pkg::status_t status;
  } chunk_report_t;

  typedef struct {
    bit            set_cfg;
    logic [39:0]   file_val;
    logic [31:0]   chunk_val;
    logic [2:0]    mode;
    logic [31:0]   idx;
    bit            typed;
    chunk_report_t want;
  } plan_row_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [tcp_pkg::ADDR_W-1:0]    paddr = '0;
  logic [tcp_pkg::PDATA_W-1:0]   pwdata = '0;
  logic [tcp_pkg::PDATA_W-1:0]   prdata;
  logic                          pready;

  tcp_cmd_if cmd_bus ();
  tcp_res_if res_bus ();

  transfer_chunk_planner dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cmd     (cmd_bus),
    .res     (res_bus)
  );

  // planner state as the block should hold it
  logic [39:0]       cfg_file = '0;
  logic [31:0]       cfg_chunk = '0;
  logic [39:0]       plan_size = '0;
  logic [39:0]       plan_total = '0;
  logic [39:0]       plan_cur = '0;
  logic [39:0]       plan_sent = '0;
  tcp_pkg::status_t  plan_status = tcp_pkg::ST_IDLE;

  chunk_report_t   report_q[$];
  plan_row_t       plan_rows[$];
  chunk_report_t   got_report;
  chunk_report_t   want_report;
  int              fail_count = 0;
  int              res_seen = 0;
  int              cmds_sent = 0;
  int              stop_at = 0;
  int              cycle_count = 0;
  int              ready_burst = 0;
  bit              idle_on = 1'b1;

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    cmd_bus.valid       = 1'b0;
    cmd_bus.mode        = tcp_pkg::MODE_QUERY;
    cmd_bus.chunk_index = '0;
    res_bus.ready       = 1'b0;
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (idle_on && ready_burst == 0 && $urandom_range(0, 5) == 0)
      ready_burst = $urandom_range(1, 10);
    if (ready_burst > 0) begin
      res_bus.ready <= 1'b0;
      ready_burst = ready_burst - 1;
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  function automatic chunk_report_t make_report(input logic [39:0] total, input logic [63:0] off,
                                                input logic [31:0] len, input logic last,
                                                input logic ok, input logic [39:0] done,
                                                input logic [63:0] bytes,
                                                input tcp_pkg::status_t st);
    chunk_report_t r;
    r.total  = total;
    r.offset = off;
    r.length = len;
    r.last   = last;
    r.ok     = ok;
    r.done   = done;
    r.bytes  = bytes;
    r.status = st;
    return r;
  endfunction

  function automatic void describe_chunk(input logic [39:0] ix, output logic [63:0] off,
                                         output logic [31:0] len, output logic last,
                                         output logic ok);
    logic [127:0] prod;
    logic [63:0]  rem;
    prod = 128'(ix) * 128'(cfg_chunk);
    off  = (prod[127:64] != 0) ? '1 : prod[63:0];
    len  = '0;
    last = 1'b0;
    ok   = (ix < plan_total);
    if (ok) begin
      rem = (off < 64'(plan_size)) ? 64'(plan_size) - off : '0;
      if (rem < 64'(cfg_chunk)) begin
        len  = rem[31:0];
        last = 1'b1;
      end else begin
        len = cfg_chunk;
      end
    end
  endfunction

  function automatic chunk_report_t plan_step(input logic [2:0] m, input logic [31:0] ix);
    chunk_report_t r;
    logic [63:0]   sum_src;
    logic [63:0]   po;
    logic [31:0]   pl;
    logic          plast, pok;
    logic [64:0]   sum;
    case (m)
      tcp_pkg::MODE_START: begin
        plan_size = cfg_file;
        if (cfg_file == 0 || cfg_chunk == 0) begin
          plan_total = '0;
        end else begin
          sum_src     = 64'(cfg_file) + 64'(cfg_chunk) - 64'd1;
          sum_src     = sum_src / 64'(cfg_chunk);
          plan_total  = sum_src[39:0];
          plan_cur    = '0;
          plan_sent   = '0;
          plan_status = tcp_pkg::ST_IDLE;
        end
      end
      tcp_pkg::MODE_ADVANCE: begin
        if (plan_sent != SIZE_MAX) plan_sent = plan_sent + 1'b1;
        if (plan_cur != SIZE_MAX) plan_cur = plan_cur + 1'b1;
        plan_status = (plan_cur >= plan_total) ? tcp_pkg::ST_DONE : tcp_pkg::ST_READING;
      end
      tcp_pkg::MODE_CANCEL: plan_status = tcp_pkg::ST_CANCELLED;
      tcp_pkg::MODE_FAIL:   plan_status = tcp_pkg::ST_FAILED;
      tcp_pkg::MODE_RESET: begin
        plan_size   = '0;
        plan_total  = '0;
        plan_cur    = '0;
        plan_sent   = '0;
        plan_status = tcp_pkg::ST_IDLE;
      end
      default: ;
    endcase
    r.bytes = '0;
    if (plan_sent != 0) begin
      describe_chunk(plan_sent - 1'b1, po, pl, plast, pok);
      sum     = 65'(po) + 65'(pl);
      r.bytes = sum[64] ? '1 : sum[63:0];
      if (plan_status == tcp_pkg::ST_DONE) r.bytes = 64'(plan_size);
    end
    describe_chunk(40'(ix), r.offset, r.length, r.last, r.ok);
    r.total  = plan_total;
    r.done   = plan_sent;
    r.status = plan_status;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] w, input logic [63:0] g);
    if (w !== g) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch in transaction %0d, %s: expected %h, got %h", res_seen, name, w, g);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      got_report = make_report(res_bus.total_chunks, res_bus.chunk_offset, res_bus.chunk_length,
                               res_bus.chunk_is_last, res_bus.index_valid, res_bus.chunks_done,
                               res_bus.bytes_done, tcp_pkg::status_t'(res_bus.status));
      if (report_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result transaction %0d", res_seen);
      end else begin
        want_report = report_q.pop_front();
        check_field("total_chunks", 64'(want_report.total), 64'(got_report.total));
        check_field("chunk_offset", want_report.offset, got_report.offset);
        check_field("chunk_length", 64'(want_report.length), 64'(got_report.length));
        check_field("chunk_is_last", 64'(want_report.last), 64'(got_report.last));
        check_field("index_valid", 64'(want_report.ok), 64'(got_report.ok));
        check_field("chunks_done", 64'(want_report.done), 64'(got_report.done));
        check_field("bytes_done", want_report.bytes, got_report.bytes);
        check_field("status", 64'(want_report.status), 64'(res_bus.status));
      end
      res_seen++;
    end
  end

  task automatic write_reg(input logic sel, input logic [63:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= tcp_pkg::ADDR_W'(8 * int'(sel));
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (sel == tcp_pkg::REG_FILE_SIZE) cfg_file = val[39:0];
    else cfg_chunk = val[31:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_cmd(input logic [2:0] m, input logic [31:0] ix, input bit typed,
                          input chunk_report_t want);
    chunk_report_t predicted;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      cmd_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.mode        <= m;
    cmd_bus.chunk_index <= ix;
    do @(posedge clk); while (cmd_bus.ready !== 1'b1);
    predicted = plan_step(m, ix);
    report_q.push_back(typed ? want : predicted);
    cmds_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input bit set_cfg, input logic [39:0] fsz, input logic [31:0] csz,
                         input logic [2:0] m, input logic [31:0] ix, input bit typed,
                         input chunk_report_t want);
    plan_row_t row;
    row.set_cfg   = set_cfg;
    row.file_val  = fsz;
    row.chunk_val = csz;
    row.mode      = m;
    row.idx       = ix;
    row.typed     = typed;
    row.want      = want;
    plan_rows.push_back(row);
  endtask

  function automatic logic [31:0] pick_index();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return plan_sent[31:0];
      default:
        if (plan_total < 40'h7FFF_FFF0) return $urandom_range(0, 32'(plan_total) + 1);
        else return $urandom;
    endcase
  endfunction

  task automatic run_random_phase();
    logic [31:0] chunk;
    logic [63:0] span;
    logic [39:0] fsz;
    logic [2:0]  m;
    int          pick;
    idle_on = (cmds_sent < stop_at - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 7))
      0:       chunk = $urandom_range(1, 8);
      1, 2:    chunk = $urandom;
      3:       chunk = CHUNK_MAX;
      4:       chunk = '0;
      default: chunk = $urandom_range(1, 5000);
    endcase
    if ($urandom_range(0, 4) == 0) begin
      fsz = {8'($urandom), 32'($urandom)};
    end else begin
      span = 64'(chunk) * 64'($urandom_range(0, 11))
           + 64'($urandom_range(1, (chunk == 0) ? 32'd1 : chunk));
      fsz  = span[39:0];
    end
    if ($urandom_range(0, 19) == 0) fsz = '0;
    wait_drained();
    if (plan_total != 0 && $urandom_range(0, 7) == 0) begin
      write_reg(tcp_pkg::REG_CHUNK_SIZE, 64'(chunk));
    end else begin
      write_reg(tcp_pkg::REG_FILE_SIZE, 64'(fsz));
      write_reg(tcp_pkg::REG_CHUNK_SIZE, 64'(chunk));
      send_cmd(tcp_pkg::MODE_START, pick_index(), 1'b0, '0);
    end
    repeat ($urandom_range(4, 16)) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      m = tcp_pkg::MODE_ADVANCE;
      else if (pick < 80) m = tcp_pkg::MODE_QUERY;
      else if (pick < 85) m = tcp_pkg::MODE_CANCEL;
      else if (pick < 90) m = tcp_pkg::MODE_FAIL;
      else if (pick < 93) m = tcp_pkg::MODE_RESET;
      else if (pick < 97) m = ($urandom_range(0, 1) != 0) ? MODE_SPARE_6 : MODE_SPARE_7;
      else                m = tcp_pkg::MODE_START;
      if (cmds_sent >= stop_at - QUIET_TAIL) idle_on = 1'b0;
      send_cmd(m, pick_index(), 1'b0, '0);
    end
  endtask

  initial begin
    add_row(0, '0, '0, tcp_pkg::MODE_QUERY, 32'd0, 1, '0);
    add_row(1, '0, '0, tcp_pkg::MODE_START, 32'd0, 1, '0);
    add_row(1, 40'd1000, 32'd300, tcp_pkg::MODE_START, 32'd3, 1,
            make_report(40'd4, 64'd900, 32'd100, 1'b1, 1'b1, '0, '0, tcp_pkg::ST_IDLE));
    add_row(0, '0, '0, tcp_pkg::MODE_ADVANCE, 32'd0, 0, '0);
    add_row(0, '0, '0, tcp_pkg::MODE_ADVANCE, 32'd4, 0, '0);
    add_row(0, '0, '0, MODE_SPARE_6, 32'd1, 0, '0);
    add_row(0, '0, '0, MODE_SPARE_7, 32'd2, 0, '0);
    add_row(0, '0, '0, tcp_pkg::MODE_ADVANCE, 32'd3, 0, '0);
    add_row(0, '0, '0, tcp_pkg::MODE_ADVANCE, 32'd3, 0, '0);
    add_row(0, '0, '0, tcp_pkg::MODE_ADVANCE, 32'd0, 0, '0);
    add_row(0, '0, '0, tcp_pkg::MODE_CANCEL, 32'd1, 0, '0);
    add_row(0, '0, '0, tcp_pkg::MODE_FAIL, 32'd2, 0, '0);
    add_row(0, '0, '0, tcp_pkg::MODE_START, 32'd0, 0, '0);
    add_row(0, '0, '0, tcp_pkg::MODE_RESET, 32'd0, 1, '0);
    add_row(1, SIZE_MAX, 32'd1, tcp_pkg::MODE_START, CHUNK_MAX, 1,
            make_report(SIZE_MAX, 64'h0000_0000_FFFF_FFFF, 32'd1, 1'b0, 1'b1, '0, '0,
                        tcp_pkg::ST_IDLE));
    add_row(0, '0, '0, tcp_pkg::MODE_ADVANCE, 32'h8000_0000, 0, '0);
    add_row(1, SIZE_MAX, CHUNK_MAX, tcp_pkg::MODE_START, CHUNK_MAX, 0, '0);
    add_row(0, '0, '0, tcp_pkg::MODE_QUERY, 32'd256, 0, '0);
    add_row(0, '0, '0, tcp_pkg::MODE_ADVANCE, 32'd255, 0, '0);
    // chunk size moved after start: offsets use the new chunk size
    add_row(1, SIZE_MAX, 32'h8000_0000, tcp_pkg::MODE_QUERY, 32'd200, 0, '0);
    add_row(0, '0, '0, tcp_pkg::MODE_ADVANCE, 32'd0, 0, '0);
    // zero chunk size with chunks still outstanding
    add_row(1, SIZE_MAX, '0, tcp_pkg::MODE_QUERY, 32'd5, 0, '0);
    add_row(0, '0, '0, tcp_pkg::MODE_START, 32'd0, 0, '0);
    add_row(1, '0, 32'd5, tcp_pkg::MODE_START, 32'd0, 0, '0);
    add_row(0, '0, '0, tcp_pkg::MODE_QUERY, 32'd0, 0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan_rows[r]) begin
      if (plan_rows[r].set_cfg) begin
        wait_drained();
        write_reg(tcp_pkg::REG_FILE_SIZE, 64'(plan_rows[r].file_val));
        write_reg(tcp_pkg::REG_CHUNK_SIZE, 64'(plan_rows[r].chunk_val));
      end
      send_cmd(plan_rows[r].mode, plan_rows[r].idx, plan_rows[r].typed, plan_rows[r].want);
    end

    stop_at = cmds_sent + RANDOM_ITEMS;
    while (cmds_sent < stop_at) run_random_phase();

    idle_on = 1'b0;
    wait_drained();
    repeat (150) @(posedge clk);
    if (report_q.size() != 0) fail_count += report_q.size();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
